@@ rtl/jsu_pkg.sv @@
// jsu_pkg: shared types, character codes, error codes and the utf-8 encoder
// for the json string unescaper; no dependencies
package jsu_pkg;

	typedef enum logic [7:0] {
		PH_IDLE = 8'b0000_0001,
		PH_STR  = 8'b0000_0010,
		PH_ESC  = 8'b0000_0100,
		PH_HEX1 = 8'b0000_1000,
		PH_HIBS = 8'b0001_0000,
		PH_HIU  = 8'b0010_0000,
		PH_HEX2 = 8'b0100_0000,
		PH_DROP = 8'b1000_0000
	} phase_t;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
	localparam logic [3:0] ERR_CONTROL   = 4'd2;
	localparam logic [3:0] ERR_SHORT_ESC = 4'd3;
	localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
	localparam logic [3:0] ERR_SHORT_HEX = 4'd5;
	localparam logic [3:0] ERR_BAD_HEX   = 4'd6;
	localparam logic [3:0] ERR_MISS_LOW  = 4'd7;
	localparam logic [3:0] ERR_BAD_LOW   = 4'd8;
	localparam logic [3:0] ERR_STRAY_LOW = 4'd9;
	localparam logic [3:0] ERR_UNTERM    = 4'd10;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] hex_accum;
		logic [1:0]  digit_count;
		logic [9:0]  high_surrogate;
	} jsu_state_t;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      last_idx;
		logic            is_data;
		logic            done;
		logic [3:0]      err;
	} burst_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [1:0]      last_idx;
	} utf8_t;

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t u;
		u = '0;
		if (cp <= 21'h7F) begin
			u.b[0] = cp[7:0];
			u.last_idx = 2'd0;
		end else if (cp <= 21'h7FF) begin
			u.b[0] = {3'b110, cp[10:6]};
			u.b[1] = {2'b10, cp[5:0]};
			u.last_idx = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			u.b[0] = {4'b1110, cp[15:12]};
			u.b[1] = {2'b10, cp[11:6]};
			u.b[2] = {2'b10, cp[5:0]};
			u.last_idx = 2'd2;
		end else begin
			u.b[0] = {5'b11110, cp[20:18]};
			u.b[1] = {2'b10, cp[17:12]};
			u.b[2] = {2'b10, cp[11:6]};
			u.b[3] = {2'b10, cp[5:0]};
			u.last_idx = 2'd3;
		end
		return u;
	endfunction

endpackage

@@ rtl/json_string_unescape_utf8.sv @@
// json_string_unescape_utf8: streaming json string unescaper with utf-8 output
// items are registered, then decoded into the result register; one item per
// cycle unless a result waits on the busy register; an escape decoding to
// several utf-8 bytes holds it until all are taken; reset: awaits an opening
// quote, no result pending; depends on jsu_pkg, jsu_decode and jsu_burst
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       last,
	output logic       done_res,
	output logic [3:0] error_code
);
	import jsu_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	jsu_state_t st_q;
	jsu_state_t st_nx;
	logic       has_res;
	burst_t     burst;
	logic       free;
	logic       adv;

	assign adv = v_s1 && (!has_res || free);
	assign item_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			st_q.phase <= PH_IDLE;
			st_q.hex_accum <= '0;
			st_q.digit_count <= '0;
			st_q.high_surrogate <= '0;
		end else begin
			if (item_valid && item_ready) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				st_q <= st_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_s1 <= in_byte;
			eot_s1 <= end_of_text;
		end
	end

	jsu_decode u_decode (
		.st          (st_q),
		.in_byte     (byte_s1),
		.end_of_text (eot_s1),
		.nx          (st_nx),
		.has_res     (has_res),
		.res         (burst)
	);

	jsu_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && has_res),
		.burst      (burst),
		.free       (free),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.last       (last),
		.done_res   (done_res),
		.error_code (error_code)
	);

endmodule

@@ rtl/jsu_decode.sv @@
// jsu_decode: next-state and result burst for one text byte
// depends on jsu_pkg
module jsu_decode (
	input  jsu_pkg::jsu_state_t st,
	input  logic [7:0]          in_byte,
	input  logic                end_of_text,
	output jsu_pkg::jsu_state_t nx,
	output logic                has_res,
	output jsu_pkg::burst_t     res
);
	import jsu_pkg::*;

	logic [3:0]  hv;
	logic        hex_ok;
	logic [15:0] acc_next;
	logic [20:0] pair_cp;
	utf8_t       enc;

	always_comb begin
		hex_ok = 1'b1;
		hv = 4'd0;
		if (in_byte inside {[8'h30:8'h39]}) begin
			hv = in_byte[3:0];
		end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hv = 4'd9 + {1'b0, in_byte[2:0]};
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_next = {st.hex_accum[11:0], hv};
	assign pair_cp = 21'h10000 + {1'b0, st.high_surrogate, acc_next[9:0]};

	always_comb begin
		if (st.phase == PH_HEX2) begin
			enc = utf8_encode(pair_cp);
		end else begin
			enc = utf8_encode({5'd0, acc_next});
		end
	end

	always_comb begin
		nx = st;
		has_res = 1'b0;
		res = '0;
		res.err = ERR_NONE;
		if (end_of_text) begin
			has_res = 1'b1;
			nx.phase = PH_IDLE;
			nx.hex_accum = '0;
			nx.digit_count = '0;
			case (st.phase)
				PH_STR: res.err = ERR_UNTERM;
				PH_ESC: res.err = ERR_SHORT_ESC;
				PH_HEX1, PH_HEX2: res.err = ERR_SHORT_HEX;
				PH_HIBS, PH_HIU: res.err = ERR_MISS_LOW;
				PH_DROP: begin
					has_res = 1'b0;
					nx.high_surrogate = '0;
				end
				default: res.err = ERR_NO_QUOTE;
			endcase
		end else begin
			case (st.phase)
				PH_STR: begin
					has_res = 1'b1;
					if (in_byte == CH_QUOTE) begin
						nx.phase = PH_IDLE;
						res.done = 1'b1;
					end else if (in_byte < CH_SPACE) begin
						res.err = ERR_CONTROL;
						nx.phase = PH_DROP;
						nx.hex_accum = '0;
						nx.digit_count = '0;
					end else if (in_byte == CH_BSL) begin
						has_res = 1'b0;
						nx.phase = PH_ESC;
					end else begin
						res.is_data = 1'b1;
						res.data[0] = in_byte;
					end
				end
				PH_ESC: begin
					has_res = 1'b1;
					res.is_data = 1'b1;
					nx.phase = PH_STR;
					case (in_byte)
						CH_QUOTE, CH_BSL, CH_SLASH: res.data[0] = in_byte;
						CH_B: res.data[0] = 8'h08;
						CH_F: res.data[0] = 8'h0C;
						CH_N: res.data[0] = 8'h0A;
						CH_R: res.data[0] = 8'h0D;
						CH_T: res.data[0] = 8'h09;
						CH_U: begin
							has_res = 1'b0;
							res.is_data = 1'b0;
							nx.phase = PH_HEX1;
							nx.hex_accum = '0;
							nx.digit_count = '0;
						end
						default: begin
							res.is_data = 1'b0;
							res.err = ERR_BAD_ESC;
							nx.phase = PH_DROP;
							nx.hex_accum = '0;
							nx.digit_count = '0;
						end
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (!hex_ok) begin
						has_res = 1'b1;
						res.err = ERR_BAD_HEX;
						nx.phase = PH_DROP;
						nx.hex_accum = '0;
						nx.digit_count = '0;
					end else if (st.digit_count != 2'd3) begin
						nx.hex_accum = acc_next;
						nx.digit_count = st.digit_count + 2'd1;
					end else begin
						nx.hex_accum = '0;
						nx.digit_count = '0;
						if (st.phase == PH_HEX1 && acc_next inside {[16'hD800:16'hDBFF]}) begin
							nx.high_surrogate = acc_next[9:0];
							nx.phase = PH_HIBS;
						end else if (st.phase == PH_HEX1
								&& acc_next inside {[16'hDC00:16'hDFFF]}) begin
							has_res = 1'b1;
							res.err = ERR_STRAY_LOW;
							nx.phase = PH_DROP;
						end else if (st.phase == PH_HEX2
								&& !(acc_next inside {[16'hDC00:16'hDFFF]})) begin
							has_res = 1'b1;
							res.err = ERR_BAD_LOW;
							nx.phase = PH_DROP;
						end else begin
							has_res = 1'b1;
							res.is_data = 1'b1;
							res.data = enc.b;
							res.last_idx = enc.last_idx;
							nx.phase = PH_STR;
						end
					end
				end
				PH_HIBS: begin
					if (in_byte != CH_BSL) begin
						has_res = 1'b1;
						res.err = ERR_MISS_LOW;
						nx.phase = PH_DROP;
						nx.hex_accum = '0;
						nx.digit_count = '0;
					end else begin
						nx.phase = PH_HIU;
					end
				end
				PH_HIU: begin
					nx.hex_accum = '0;
					nx.digit_count = '0;
					if (in_byte != CH_U) begin
						has_res = 1'b1;
						res.err = ERR_MISS_LOW;
						nx.phase = PH_DROP;
					end else begin
						nx.phase = PH_HEX2;
					end
				end
				PH_DROP: begin
					if (in_byte == CH_QUOTE) begin
						nx.phase = PH_STR;
					end
				end
				default: begin
					nx.hex_accum = '0;
					nx.digit_count = '0;
					if (in_byte == CH_QUOTE) begin
						nx.phase = PH_STR;
					end else begin
						has_res = 1'b1;
						res.err = ERR_NO_QUOTE;
						nx.phase = PH_DROP;
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/jsu_burst.sv @@
// jsu_burst: result register holding one burst of up to four results,
// handed out one per cycle while res_ready is high; depends on jsu_pkg
module jsu_burst (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  jsu_pkg::burst_t burst,
	output logic            free,
	output logic            res_valid,
	input  logic            res_ready,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic            last,
	output logic            done_res,
	output logic [3:0]      error_code
);
	import jsu_pkg::*;

	burst_t     burst_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       at_last;

	assign at_last = (idx_q == burst_q.last_idx);
	assign free = !valid_q || (res_ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (valid_q && res_ready) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= burst;
		end
	end

	assign res_valid = valid_q;
	assign out_byte = burst_q.is_data ? burst_q.data[idx_q] : 8'd0;
	assign out_valid = burst_q.is_data;
	assign last = at_last;
	assign done_res = burst_q.done;
	assign error_code = burst_q.err;

endmodule

@@ tb/sv/tb_json_string_unescape_utf8.sv @@
// tb_json_string_unescape_utf8: self-checking testbench for the streaming json string
// unescaper; a directed table, then random texts checked against a built-in decoder
// depends on jsu_pkg and json_string_unescape_utf8
module tb_json_string_unescape_utf8;
	timeunit 1ns;
	timeprecision 1ps;

	import jsu_pkg::*;

	localparam int RAND_ITEMS = 320;
	localparam int LIMIT      = 2000;
	localparam int DRAIN      = 8;

	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  CH_NINE    = 8'h39;
	localparam logic [7:0]  CH_LA      = 8'h61;
	localparam logic [7:0]  CH_LF      = 8'h66;
	localparam logic [7:0]  CH_UA      = 8'h41;
	localparam logic [7:0]  CH_UF      = 8'h46;
	localparam logic [15:0] SUR_HI_MIN = 16'hD800;
	localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] PLANE1     = 21'h10000;

	typedef struct packed {
		logic [7:0] data;
		logic       vld;
		logic       lst;
		logic       dn;
		logic [3:0] err;
	} res_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eot;
	} stim_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eot;
		logic       typed;
		logic       dn;
		logic [3:0] err;
	} row_t;

	localparam logic [7:0] ESC_CHARS [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N,
		CH_R, CH_T};

	localparam row_t DIRECTED [27] = '{
		'{8'h00, 1'b1, 1'b1, 1'b0, ERR_NO_QUOTE},
		'{8'hFF, 1'b0, 1'b1, 1'b0, ERR_NO_QUOTE},
		'{8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_QUOTE, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h1F, 1'b0, 1'b1, 1'b0, ERR_CONTROL},
		'{8'hA5, 1'b1, 1'b0, 1'b0, ERR_NONE},
		'{CH_QUOTE, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_SPACE, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_BSL, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"q", 1'b0, 1'b1, 1'b0, ERR_BAD_ESC},
		'{CH_QUOTE, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_BSL, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_U, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"D", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"b", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"f", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"F", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_BSL, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_U, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"d", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"f", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"F", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{"f", 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{CH_QUOTE, 1'b0, 1'b1, 1'b1, ERR_NONE},
		'{CH_QUOTE, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h5A, 1'b1, 1'b1, 1'b0, ERR_UNTERM}
	};

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	logic [7:0] in_byte;
	logic       end_of_text;
	logic       res_valid;
	logic       res_ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       last;
	logic       done_res;
	logic [3:0] error_code;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.in_byte(in_byte),
		.end_of_text(end_of_text),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.last(last),
		.done_res(done_res),
		.error_code(error_code)
	);

	// decoder state
	phase_t      ph;
	logic [15:0] acc;
	logic [1:0]  ndig;
	logic [9:0]  hi_sur;

	res_t  decoded_q[$];
	stim_t text_q[$];

	int src_idle;
	int sink_stall;
	int errors;
	int n_items;
	int n_texts;
	int n_res;
	int n_done;
	int n_err_res;
	int idle_cycles;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	task automatic queue_res(input res_t r);
		decoded_q = {decoded_q, r};
	endtask

	task automatic push_byte(input logic [7:0] d);
		queue_res('{d, 1'b1, 1'b0, 1'b0, ERR_NONE});
	endtask

	task automatic fail(input logic [3:0] err, input phase_t next);
		queue_res('{8'h00, 1'b0, 1'b0, 1'b0, err});
		ph = next;
		acc = '0;
		ndig = '0;
	endtask

	task automatic emit_cp(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			push_byte(cp[7:0]);
		end else if (cp <= 21'h7FF) begin
			push_byte(8'hC0 | 8'(cp >> 6));
			push_byte(8'h80 | 8'(cp & 21'h3F));
		end else if (cp <= 21'hFFFF) begin
			push_byte(8'hE0 | 8'(cp >> 12));
			push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			push_byte(8'h80 | 8'(cp & 21'h3F));
		end else begin
			push_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
			push_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
			push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			push_byte(8'h80 | 8'(cp & 21'h3F));
		end
	endtask

	task automatic decode_item(input logic [7:0] c, input logic eot);
		int          h;
		int          n0;
		logic [15:0] v;
		res_t        r;
		n0 = decoded_q.size();
		if (eot) begin
			case (ph)
				PH_STR: fail(ERR_UNTERM, PH_IDLE);
				PH_ESC: fail(ERR_SHORT_ESC, PH_IDLE);
				PH_HEX1, PH_HEX2: fail(ERR_SHORT_HEX, PH_IDLE);
				PH_HIBS, PH_HIU: fail(ERR_MISS_LOW, PH_IDLE);
				PH_DROP: begin
					ph = PH_IDLE;
					acc = '0;
					ndig = '0;
					hi_sur = '0;
				end
				default: fail(ERR_NO_QUOTE, PH_IDLE);
			endcase
		end else begin
			case (ph)
				PH_STR: begin
					if (c == CH_QUOTE) begin
						ph = PH_IDLE;
						queue_res('{8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE});
					end else if (c < CH_SPACE) begin
						fail(ERR_CONTROL, PH_DROP);
					end else if (c == CH_BSL) begin
						ph = PH_ESC;
					end else begin
						push_byte(c);
					end
				end
				PH_ESC: begin
					ph = PH_STR;
					case (c)
						CH_QUOTE, CH_BSL, CH_SLASH: push_byte(c);
						CH_B: push_byte(8'h08);
						CH_F: push_byte(8'h0C);
						CH_N: push_byte(8'h0A);
						CH_R: push_byte(8'h0D);
						CH_T: push_byte(8'h09);
						CH_U: begin
							ph = PH_HEX1;
							acc = '0;
							ndig = '0;
						end
						default: fail(ERR_BAD_ESC, PH_DROP);
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					h = hex_nibble(c);
					if (h < 0) begin
						fail(ERR_BAD_HEX, PH_DROP);
					end else begin
						acc = {acc[11:0], 4'(h)};
						if (ndig < 2'd3) begin
							ndig = ndig + 2'd1;
						end else begin
							ndig = '0;
							v = acc;
							acc = '0;
							if (ph == PH_HEX1) begin
								if (v >= SUR_HI_MIN && v <= SUR_HI_MAX) begin
									hi_sur = 10'(v - SUR_HI_MIN);
									ph = PH_HIBS;
								end else if (v >= SUR_LO_MIN && v <= SUR_LO_MAX) begin
									fail(ERR_STRAY_LOW, PH_DROP);
								end else begin
									ph = PH_STR;
									emit_cp(21'(v));
								end
							end else if (v < SUR_LO_MIN || v > SUR_LO_MAX) begin
								fail(ERR_BAD_LOW, PH_DROP);
							end else begin
								ph = PH_STR;
								emit_cp(PLANE1 + {hi_sur, 10'd0} + 21'(v - SUR_LO_MIN));
							end
						end
					end
				end
				PH_HIBS: begin
					if (c != CH_BSL) fail(ERR_MISS_LOW, PH_DROP);
					else ph = PH_HIU;
				end
				PH_HIU: begin
					if (c != CH_U) begin
						fail(ERR_MISS_LOW, PH_DROP);
					end else begin
						ph = PH_HEX2;
						acc = '0;
						ndig = '0;
					end
				end
				PH_DROP: begin
					if (c == CH_QUOTE) ph = PH_STR;
				end
				default: begin
					if (c != CH_QUOTE) begin
						fail(ERR_NO_QUOTE, PH_DROP);
					end else begin
						ph = PH_STR;
						acc = '0;
						ndig = '0;
					end
				end
			endcase
		end
		if (decoded_q.size() > n0) begin
			r = decoded_q.pop_back();
			r.lst = 1'b1;
			queue_res(r);
		end
	endtask

	task automatic send_item(input logic [7:0] d, input logic eot, input logic typed,
		input logic dn, input logic [3:0] err);
		int n0;
		while ($urandom_range(99) < src_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		in_byte <= d;
		end_of_text <= eot;
		do @(posedge clk); while (!item_ready);
		n0 = decoded_q.size();
		decode_item(d, eot);
		if (typed) begin
			while (decoded_q.size() > n0) void'(decoded_q.pop_back());
			queue_res('{8'h00, 1'b0, 1'b1, dn, err});
		end
		n_items++;
	endtask

	task automatic check_result();
		res_t e;
		n_res++;
		if (done_res) n_done++;
		if (error_code != ERR_NONE) n_err_res++;
		if (decoded_q.size() == 0) begin
			$error("result with nothing expected: out_byte %0h error_code %0d",
				out_byte, error_code);
			errors++;
			return;
		end
		e = decoded_q.pop_front();
		if (out_byte !== e.data) begin
			$error("out_byte expected %0h actual %0h", e.data, out_byte);
			errors++;
		end
		if (out_valid !== e.vld) begin
			$error("out_valid expected %0b actual %0b", e.vld, out_valid);
			errors++;
		end
		if (last !== e.lst) begin
			$error("last expected %0b actual %0b", e.lst, last);
			errors++;
		end
		if (done_res !== e.dn) begin
			$error("done_res expected %0b actual %0b", e.dn, done_res);
			errors++;
		end
		if (error_code !== e.err) begin
			$error("error_code expected %0d actual %0d", e.err, error_code);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) check_result();
			if ((res_valid && res_ready) || (item_valid && item_ready)) begin
				idle_cycles = 0;
			end else if (idle_cycles >= LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles++;
			end
			res_ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return CH_ZERO + 8'(n);
		return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(n - 4'd10);
	endfunction

	function automatic logic is_esc(input logic [7:0] c);
		foreach (ESC_CHARS[i]) if (c == ESC_CHARS[i]) return 1'b1;
		return c == CH_U;
	endfunction

	function automatic logic [7:0] non_quote();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
		return c;
	endfunction

	function automatic logic [15:0] bmp_value();
		logic [15:0] edges [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
			16'hD7FF, 16'hE000, 16'hFFFF};
		if ($urandom_range(7) == 0) return edges[$urandom_range(7)];
		case ($urandom_range(3))
			0: return 16'($urandom_range(16'h7F));
			1: return 16'($urandom_range(16'h7FF, 16'h80));
			2: return 16'($urandom_range(16'hD7FF, 16'h800));
			default: return 16'($urandom_range(16'hFFFF, 16'hE000));
		endcase
	endfunction

	function automatic logic [15:0] high_half();
		return SUR_HI_MIN + 16'($urandom_range(10'h3FF));
	endfunction

	task automatic add(input logic [7:0] d, input logic eot);
		text_q = {text_q, stim_t'{d, eot}};
	endtask

	task automatic add_digits(input logic [15:0] v, input int n);
		for (int i = 0; i < n; i++) add(hex_char(v[15 - 4 * i -: 4]), 1'b0);
	endtask

	task automatic add_u(input logic [15:0] v);
		add(CH_BSL, 1'b0);
		add(CH_U, 1'b0);
		add_digits(v, 4);
	endtask

	task automatic add_good_piece();
		logic [7:0] c;
		case ($urandom_range(5))
			0, 1: begin
				do c = 8'($urandom_range(255, 32)); while (c == CH_QUOTE || c == CH_BSL);
				add(c, 1'b0);
			end
			2: begin
				add(CH_BSL, 1'b0);
				add(ESC_CHARS[$urandom_range(7)], 1'b0);
			end
			3: add_u(bmp_value());
			default: begin
				add_u(high_half());
				add_u(SUR_LO_MIN + 16'($urandom_range(10'h3FF)));
			end
		endcase
	endtask

	task automatic add_broken_piece();
		logic [7:0]  c;
		logic [15:0] v;
		case ($urandom_range(6))
			0: add(8'($urandom_range(8'h1F)), 1'b0);
			1: begin
				do c = 8'($urandom_range(255)); while (is_esc(c));
				add(CH_BSL, 1'b0);
				add(c, 1'b0);
			end
			2, 6: begin
				if ($urandom_range(6) == 6) add_u(high_half());
				add(CH_BSL, 1'b0);
				add(CH_U, 1'b0);
				add_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
				do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
				add(c, 1'b0);
			end
			3: add_u(SUR_LO_MIN + 16'($urandom_range(10'h3FF)));
			4: begin
				add_u(high_half());
				if ($urandom_range(1)) begin
					do c = 8'($urandom_range(255)); while (c == CH_BSL);
					add(c, 1'b0);
				end else begin
					add(CH_BSL, 1'b0);
					do c = 8'($urandom_range(255)); while (c == CH_U);
					add(c, 1'b0);
				end
			end
			default: begin
				add_u(high_half());
				do v = 16'($urandom_range(16'hFFFF)); while (v >= SUR_LO_MIN && v <= SUR_LO_MAX);
				add_u(v);
			end
		endcase
	endtask

	task automatic add_truncated_end();
		case ($urandom_range(3))
			0: add(CH_BSL, 1'b0);
			1: begin
				add(CH_BSL, 1'b0);
				add(CH_U, 1'b0);
				add_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
			end
			2: begin
				add_u(high_half());
				case ($urandom_range(2))
					0: ;
					1: add(CH_BSL, 1'b0);
					default: begin
						add(CH_BSL, 1'b0);
						add(CH_U, 1'b0);
						add_digits(SUR_LO_MIN, $urandom_range(3));
					end
				endcase
			end
			default: ;
		endcase
		add(8'($urandom_range(255)), 1'b1);
	endtask

	// one text: opening, content, then a clean close or a failure; always ends awaiting a quote
	task automatic gen_text();
		int r;
		r = $urandom_range(99);
		if (r < 5) begin
			repeat ($urandom_range(3, 1)) add(non_quote(), 1'b0);
		end else if (r < 8) begin
			add(8'($urandom_range(255)), 1'b1);
		end
		add(CH_QUOTE, 1'b0);
		repeat ($urandom_range(6)) add_good_piece();
		if ($urandom_range(99) < 20) begin
			add_broken_piece();
			repeat ($urandom_range(3)) add(non_quote(), 1'b0);
			if ($urandom_range(99) < 70) begin
				add(8'($urandom_range(255)), 1'b1);
			end else begin
				add(CH_QUOTE, 1'b0);
				add_good_piece();
				add(CH_QUOTE, 1'b0);
			end
		end else begin
			r = $urandom_range(99);
			if (r < 85) add(CH_QUOTE, 1'b0);
			else add_truncated_end();
		end
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin src_idle = 0; sink_stall = 0; end
			1: begin src_idle = 85; sink_stall = 0; end
			2: begin src_idle = 0; sink_stall = 85; end
			default: begin src_idle = 15; sink_stall = 15; end
		endcase
	endtask

	initial begin
		int    mode;
		int    n_rand;
		stim_t s;
		arst_n = 1'b0;
		item_valid = 1'b0;
		in_byte = 8'h00;
		end_of_text = 1'b0;
		res_ready = 1'b0;
		errors = 0;
		n_items = 0;
		n_texts = 0;
		n_res = 0;
		n_done = 0;
		n_err_res = 0;
		idle_cycles = 0;
		ph = PH_IDLE;
		acc = '0;
		ndig = '0;
		hi_sur = '0;
		set_idling(0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_item(DIRECTED[i].data, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].dn,
				DIRECTED[i].err);

		n_rand = 0;
		mode = 0;
		while (n_rand < RAND_ITEMS) begin
			if (n_rand * 4 / RAND_ITEMS != mode) begin
				// hold off until the block has drained, then change idling
				item_valid <= 1'b0;
				@(posedge clk);
				while (decoded_q.size() != 0) @(posedge clk);
				mode = n_rand * 4 / RAND_ITEMS;
				set_idling(mode);
			end
			gen_text();
			n_texts++;
			while (text_q.size() != 0) begin
				s = text_q.pop_front();
				send_item(s.data, s.eot, 1'b0, 1'b0, ERR_NONE);
				n_rand++;
			end
		end
		item_valid <= 1'b0;

		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d items over %0d random texts and a directed table", n_items,
			n_texts);
		$display("checked %0d results: %0d string ends, %0d error reports", n_res, n_done,
			n_err_res);
		if (errors == 0 && decoded_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
